// ===== src/box_iou_unit_defines.svh =====
// assertion macros for the box iou unit checker
// expects clock and reset in the scope of use
`ifndef BOX_IOU_UNIT_DEFINES_SVH
`define BOX_IOU_UNIT_DEFINES_SVH

// checked outside reset
`define BIOU_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// checked at every edge, reset included
`define BIOU_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

// ===== src/biou_pkg.sv =====
// types and constants shared by the box iou unit
// no dependencies
package biou_pkg;

   localparam int COORD_W = 16;
   localparam int RATIO_W = 17;
   localparam int INTER_W = 32;
   localparam int AREA_W  = 34;
   localparam int UNION_W = 36;
   localparam int DIV_W   = 34;
   localparam int REM_W   = DIV_W + RATIO_W - 1;

   localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(65536);

   typedef struct packed {
      logic signed [COORD_W-1:0] a_left;
      logic signed [COORD_W-1:0] a_top;
      logic signed [COORD_W-1:0] a_right;
      logic signed [COORD_W-1:0] a_bottom;
      logic signed [COORD_W-1:0] b_left;
      logic signed [COORD_W-1:0] b_top;
      logic signed [COORD_W-1:0] b_right;
      logic signed [COORD_W-1:0] b_bottom;
   } req_type;

   typedef struct packed {
      logic [RATIO_W-1:0] overlap_ratio;
      logic               union_empty;
   } rsp_type;

   typedef struct packed {
      logic [INTER_W-1:0] inter;
      logic [DIV_W-1:0]   divisor;
      logic               union_empty;
   } qent_type;

endpackage

// ===== src/biou_front.sv =====
// front end: intersection extents, box areas, union and empty flag
// depends on biou_pkg
module biou_front import biou_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  req_type  req_data,
   output logic     push_valid,
   input  logic     push_ready,
   output qent_type push_data
);

   logic                      s1_v_ff;
   logic [COORD_W-1:0]        iw_ff, ih_ff;
   logic signed [COORD_W:0]   wa_ff, ha_ff, wb_ff, hb_ff;
   logic [COORD_W-1:0]        iw_in, ih_in;
   logic signed [COORD_W:0]   wa_in, ha_in, wb_in, hb_in;

   logic                      s2_v_ff;
   logic [INTER_W-1:0]        inter_ff;
   logic signed [AREA_W-1:0]  area_a_ff, area_b_ff;

   logic                      s1_adv, s2_adv;
   logic signed [COORD_W-1:0] lo_x, hi_x, lo_y, hi_y;
   logic signed [COORD_W:0]   dx, dy;
   logic signed [UNION_W-1:0] uni;

   assign s2_adv    = !s2_v_ff || push_ready;
   assign s1_adv    = !s1_v_ff || s2_adv;
   assign req_ready = s1_adv;

   always_comb begin
      lo_x  = (req_data.a_left > req_data.b_left) ? req_data.a_left : req_data.b_left;
      hi_x  = (req_data.a_right < req_data.b_right) ? req_data.a_right : req_data.b_right;
      lo_y  = (req_data.a_top > req_data.b_top) ? req_data.a_top : req_data.b_top;
      hi_y  = (req_data.a_bottom < req_data.b_bottom) ? req_data.a_bottom : req_data.b_bottom;
      dx    = {hi_x[COORD_W-1], hi_x} - {lo_x[COORD_W-1], lo_x};
      dy    = {hi_y[COORD_W-1], hi_y} - {lo_y[COORD_W-1], lo_y};
      iw_in = (dx > 0) ? dx[COORD_W-1:0] : '0;
      ih_in = (dy > 0) ? dy[COORD_W-1:0] : '0;
      wa_in = {req_data.a_right[COORD_W-1], req_data.a_right}
            - {req_data.a_left[COORD_W-1], req_data.a_left};
      ha_in = {req_data.a_bottom[COORD_W-1], req_data.a_bottom}
            - {req_data.a_top[COORD_W-1], req_data.a_top};
      wb_in = {req_data.b_right[COORD_W-1], req_data.b_right}
            - {req_data.b_left[COORD_W-1], req_data.b_left};
      hb_in = {req_data.b_bottom[COORD_W-1], req_data.b_bottom}
            - {req_data.b_top[COORD_W-1], req_data.b_top};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (s1_adv) begin
         s1_v_ff <= req_valid;
      end
      if (s1_adv) begin
         iw_ff <= iw_in;
         ih_ff <= ih_in;
         wa_ff <= wa_in;
         ha_ff <= ha_in;
         wb_ff <= wb_in;
         hb_ff <= hb_in;
      end
   end

   // one multiplier per product
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (s2_adv) begin
         s2_v_ff <= s1_v_ff;
      end
      if (s2_adv) begin
         inter_ff  <= INTER_W'(iw_ff) * INTER_W'(ih_ff);
         area_a_ff <= AREA_W'(wa_ff) * AREA_W'(ha_ff);
         area_b_ff <= AREA_W'(wb_ff) * AREA_W'(hb_ff);
      end
   end

   always_comb begin
      uni = {{(UNION_W-AREA_W){area_a_ff[AREA_W-1]}}, area_a_ff}
          + {{(UNION_W-AREA_W){area_b_ff[AREA_W-1]}}, area_b_ff}
          - {{(UNION_W-INTER_W){1'b0}}, inter_ff};
      push_valid             = s2_v_ff;
      push_data.inter        = inter_ff;
      push_data.divisor      = uni[DIV_W-1:0];
      push_data.union_empty  = uni[UNION_W-1] || (uni == '0);
   end

endmodule

// ===== src/biou_queue.sv =====
// short register queue between front end and divider
// depends on biou_pkg
module biou_queue import biou_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  qent_type in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output qent_type out_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   qent_type         mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             push, pop;

   assign out_valid = (count_ff != '0);
   assign in_ready  = (count_ff != CNT_W'(DEPTH)) || out_ready;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_data  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// ===== src/biou_back.sv =====
// back end: pipelined restoring divider, one quotient bit per stage
// depends on biou_pkg
module biou_back import biou_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     pop_valid,
   output logic     pop_ready,
   input  qent_type pop_data,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data
);

   localparam int NSTEP = RATIO_W;

   logic               v_ff   [NSTEP];
   logic [REM_W-1:0]   rem_ff [NSTEP];
   logic [DIV_W-1:0]   d_ff   [NSTEP];
   logic [RATIO_W-1:0] q_ff   [NSTEP];
   logic               e_ff   [NSTEP];

   logic [REM_W-1:0]   rem_in [NSTEP+1];
   logic [RATIO_W-1:0] q_in   [NSTEP+1];

   logic               out_v_ff;
   rsp_type            out_ff;
   rsp_type            out_in;
   logic               adv;

   assign adv       = !out_v_ff || rsp_ready;
   assign pop_ready = adv;
   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   assign rem_in[0] = {{(REM_W-INTER_W-RATIO_W+1){1'b0}}, pop_data.inter, {(RATIO_W-1){1'b0}}};
   assign q_in[0]   = '0;

   for (genvar j = 0; j < NSTEP; j++) begin : g_step
      localparam int K = NSTEP - 1 - j;
      logic [REM_W-1:0] dsh;
      logic [REM_W:0]   diff;

      assign dsh  = {{(REM_W-DIV_W){1'b0}}, d_ff[j]} << K;
      assign diff = {1'b0, rem_ff[j]} - {1'b0, dsh};
      assign rem_in[j+1] = diff[REM_W] ? rem_ff[j] : diff[REM_W-1:0];
      assign q_in[j+1]   = q_ff[j] | (RATIO_W'(!diff[REM_W]) << K);

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else if (adv) begin
            v_ff[j] <= (j == 0) ? pop_valid : v_ff[(j == 0) ? 0 : j-1];
         end
         if (adv) begin
            rem_ff[j] <= rem_in[j];
            q_ff[j]   <= q_in[j];
            d_ff[j]   <= (j == 0) ? pop_data.divisor : d_ff[(j == 0) ? 0 : j-1];
            e_ff[j]   <= (j == 0) ? pop_data.union_empty : e_ff[(j == 0) ? 0 : j-1];
         end
      end
   end

   always_comb begin
      out_in.union_empty = e_ff[NSTEP-1];
      if (e_ff[NSTEP-1]) begin
         out_in.overlap_ratio = '0;
      end else if (q_in[NSTEP] > RATIO_ONE) begin
         out_in.overlap_ratio = RATIO_ONE;
      end else begin
         out_in.overlap_ratio = q_in[NSTEP];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= v_ff[NSTEP-1];
      end
      if (adv) begin
         out_ff <= out_in;
      end
   end

endmodule

// ===== src/box_iou_unit.sv =====
// intersection over union of two boxes; one box pair per cycle sustained while
// the result side is ready, since a stalled result holds the pipeline
// results pass two front stages, the queue, then the 17-stage divider
// reset clears all valid flags and queue pointers; data registers keep values
// depends on biou_pkg, biou_front, biou_queue, biou_back
module box_iou_unit import biou_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic     push_valid, push_ready;
   qent_type push_data;
   logic     pop_valid, pop_ready;
   qent_type pop_data;

   biou_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   biou_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   (push_data),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_data  (pop_data)
   );

   biou_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== src/biou_checker.sv =====
// port-level checks for box_iou_unit, bound to the top level
// depends on biou_pkg and box_iou_unit_defines.svh
`include "box_iou_unit_defines.svh"

module biou_checker import biou_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   `BIOU_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "result changed while stalled")
   `BIOU_ASSERT(a_empty_zero, rsp_valid && rsp_data.union_empty |-> rsp_data.overlap_ratio == '0, "empty union with nonzero ratio")
   `BIOU_ASSERT(a_ratio_max, rsp_valid |-> rsp_data.overlap_ratio <= RATIO_ONE, "ratio above one")
   `BIOU_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_valid, "result valid right after reset")

endmodule

bind box_iou_unit biou_checker u_biou_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
